[hw/rtl/fnlp_pkg.sv]
// ============================================================================
// fnlp_pkg - shared types and constants of the number literal parser
// Item structs, the classified queue entry, character codes and radixes.
// ============================================================================
package fnlp_pkg;

    // Input item: one character of a word
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    // Result item: one per word
    typedef struct packed {
        logic        valid_res;
        logic [31:0] value;
    } t_out_item;

    // Classified character as it travels from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [5:0] dig;
        logic       dig_ok;
        logic       space;
    } t_cls;

    // Queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Radix values
    localparam logic [5:0] BASE_RESET = 6'd10;
    localparam logic [5:0] BASE_MIN   = 6'd2;
    localparam logic [5:0] BASE_MAX   = 6'd36;
    localparam logic [5:0] HEX_LIMIT  = 6'd33;
    localparam logic [5:0] RADIX_DEC  = 6'd10;
    localparam logic [5:0] RADIX_BIN  = 6'd2;
    localparam logic [5:0] RADIX_HEX  = 6'd16;

    // Character codes
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_H   = 8'h68;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] LETTER_OFS = 8'd10;

endpackage

[hw/rtl/fnlp_front.sv]
// ============================================================================
// fnlp_front - input side of the number literal parser
// Accepts characters, classifies them as digits and white space, pushes
// them into the queue, and holds the default base register.
// ============================================================================
module fnlp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  fnlp_pkg::t_in_item i_in_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [5:0]       i_cfg_data,
    output logic [5:0]       o_base,
    input  logic             i_full,
    output logic             o_push,
    output fnlp_pkg::t_cls   o_push_item
);
    import fnlp_pkg::*;

    logic [5:0] r_base;
    logic [7:0] w_ch;
    logic [7:0] w_dig8;

    // Stall whenever the queue has no room
    assign o_in_stall  = i_full;
    assign o_push      = i_in_valid && !i_full;
    assign o_cfg_ready = 1'b1;
    assign o_base      = r_base;

    // Classify the character
    assign w_ch = i_in_item.ch;

    always_comb begin
        o_push_item.ch     = w_ch;
        o_push_item.last   = i_in_item.last;
        o_push_item.dig_ok = 1'b1;
        w_dig8             = 8'd0;
        if (w_ch >= CH_ZERO && w_ch <= CH_NINE) begin
            w_dig8 = w_ch - CH_ZERO;
        end else if (w_ch >= CH_LOW_A && w_ch <= CH_LOW_Z) begin
            w_dig8 = w_ch - CH_LOW_A + LETTER_OFS;
        end else if (w_ch >= CH_UP_A && w_ch <= CH_UP_Z) begin
            w_dig8 = w_ch - CH_UP_A + LETTER_OFS;
        end else begin
            o_push_item.dig_ok = 1'b0;
        end
        o_push_item.dig   = w_dig8[5:0];
        o_push_item.space = (w_ch == CH_SPACE) || (w_ch >= CH_TAB && w_ch <= CH_CR);
    end

    // Hold the default base; drop writes outside the legal range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_valid && i_cfg_data >= BASE_MIN && i_cfg_data <= BASE_MAX) begin
            r_base <= i_cfg_data;
        end
    end

endmodule

[hw/rtl/fnlp_queue.sv]
// ============================================================================
// fnlp_queue - classified character queue
// Short first-in first-out buffer that decouples the front from the back.
// ============================================================================
module fnlp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fnlp_pkg::t_cls i_push_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output fnlp_pkg::t_cls o_head
);
    import fnlp_pkg::*;

    t_cls                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count past depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

[hw/rtl/fnlp_back.sv]
// ============================================================================
// fnlp_back - parse engine of the number literal parser
// Walks the word grammar one character per cycle when not stalled, accumulates
// digits into a 64-bit magnitude and registers one result per word.
// ============================================================================
module fnlp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [5:0]        i_base,
    input  logic              i_empty,
    input  fnlp_pkg::t_cls    i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fnlp_pkg::t_out_item o_out_item
);
    import fnlp_pkg::*;

    typedef enum logic [3:0] {
        PH_SIGN, PH_PREFIX, PH_PZERO, PH_WS, PH_ISIGNED, PH_IZERO,
        PH_IX, PH_DIGITS, PH_Q1, PH_Q2, PH_Q3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_neg_o, n_neg_o;
    logic        r_neg_i, n_neg_i;
    logic [5:0]  r_radix, n_radix;
    logic [63:0] r_acc, n_acc;
    logic        r_failed, n_failed;
    logic        r_seen, n_seen;
    logic [7:0]  r_code, n_code;
    logic        r_out_valid;
    t_out_item   r_out_item, n_out_item;

    logic        n_again;
    logic        n_do_digit;
    logic [7:0]  w_c;
    logic [69:0] w_prod;
    logic [70:0] w_sum;
    logic [31:0] w_mag;
    logic        w_neg;

    assign w_c = i_head.ch;

    // Pop when the item leaves no result, or the output register can take one
    assign o_pop = !i_empty && (!i_head.last || !r_out_valid || !i_out_stall);

    // Walk the grammar phases this character passes through
    always_comb begin
        n_phase    = r_phase;
        n_neg_o    = r_neg_o;
        n_neg_i    = r_neg_i;
        n_radix    = r_radix;
        n_acc      = r_acc;
        n_failed   = r_failed;
        n_seen     = r_seen;
        n_code     = r_code;
        n_again    = 1'b1;
        n_do_digit = 1'b0;
        for (int i = 0; i < 5; i++) begin
            if (n_again && !n_failed) begin
                n_again = 1'b0;
                case (n_phase)
                    PH_SIGN: begin
                        n_radix = i_base;
                        n_phase = PH_PREFIX;
                        if (w_c == CH_MINUS) begin
                            n_neg_o = 1'b1;
                        end else if (w_c != CH_PLUS) begin
                            n_again = 1'b1;
                        end
                    end
                    PH_PREFIX: begin
                        if (w_c == CH_AMP || w_c == CH_HASH) begin
                            n_radix = RADIX_DEC;
                            n_phase = PH_WS;
                        end else if (w_c == CH_LOW_B || w_c == CH_PCT) begin
                            n_radix = RADIX_BIN;
                            n_phase = PH_WS;
                        end else if (w_c == CH_LOW_H || w_c == CH_DOLLAR) begin
                            if (i_base >= HEX_LIMIT) begin
                                n_failed = 1'b1;
                            end else begin
                                n_radix = RADIX_HEX;
                                n_phase = PH_WS;
                            end
                        end else if (w_c == CH_ZERO) begin
                            n_phase = PH_PZERO;
                        end else if (w_c == CH_QUOTE) begin
                            n_phase = PH_Q1;
                        end else begin
                            n_phase = PH_WS;
                            n_again = 1'b1;
                        end
                    end
                    PH_PZERO: begin
                        if (w_c == CH_LOW_X) begin
                            if (i_base >= HEX_LIMIT) begin
                                n_failed = 1'b1;
                            end else begin
                                n_radix = RADIX_HEX;
                                n_phase = PH_WS;
                            end
                        end else begin
                            // Lone zero counts as a digit; magnitude is still zero
                            n_seen  = 1'b1;
                            n_phase = (n_radix == RADIX_HEX) ? PH_IZERO : PH_DIGITS;
                            n_again = 1'b1;
                        end
                    end
                    PH_WS: begin
                        if (!i_head.space) begin
                            n_phase = PH_ISIGNED;
                            if (w_c == CH_MINUS) begin
                                n_neg_i = 1'b1;
                            end else if (w_c != CH_PLUS) begin
                                n_again = 1'b1;
                            end
                        end
                    end
                    PH_ISIGNED: begin
                        if (n_radix == RADIX_HEX && w_c == CH_ZERO) begin
                            n_seen  = 1'b1;
                            n_phase = PH_IZERO;
                        end else begin
                            n_phase = PH_DIGITS;
                            n_again = 1'b1;
                        end
                    end
                    PH_IZERO: begin
                        if (w_c == CH_LOW_X || w_c == CH_UP_X) begin
                            n_phase = PH_IX;
                        end else begin
                            n_phase = PH_DIGITS;
                            n_again = 1'b1;
                        end
                    end
                    PH_IX: begin
                        if (i_head.dig_ok && i_head.dig < RADIX_HEX) begin
                            n_phase = PH_DIGITS;
                            n_again = 1'b1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        n_do_digit = 1'b1;
                    end
                    PH_Q1: begin
                        n_code  = w_c;
                        n_phase = PH_Q2;
                    end
                    PH_Q2: begin
                        if (w_c == CH_QUOTE) begin
                            n_phase = PH_Q3;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    default: begin
                        n_failed = 1'b1;
                    end
                endcase
            end
        end

        // Multiply-add one digit, flag overflow past 64 bits
        w_prod = {6'd0, r_acc} * {64'd0, n_radix};
        w_sum  = {1'b0, w_prod} + {65'd0, i_head.dig};
        if (n_do_digit) begin
            if (!i_head.dig_ok || i_head.dig >= n_radix) begin
                n_failed = 1'b1;
            end else if (w_sum[70:64] != 7'd0) begin
                n_failed = 1'b1;
            end else begin
                n_acc  = w_sum[63:0];
                n_seen = 1'b1;
            end
        end
    end

    // Form the word result
    always_comb begin
        n_out_item.valid_res = 1'b0;
        w_mag                = 32'd0;
        w_neg                = 1'b0;
        if (!n_failed) begin
            if (n_phase == PH_Q2 || n_phase == PH_Q3) begin
                n_out_item.valid_res = 1'b1;
                w_mag                = {24'd0, n_code};
                w_neg                = n_neg_o;
            end else if ((n_phase == PH_PZERO || n_phase == PH_IZERO ||
                          n_phase == PH_DIGITS) && n_seen) begin
                n_out_item.valid_res = 1'b1;
                w_mag                = (n_phase == PH_PZERO) ? 32'd0 : n_acc[31:0];
                w_neg                = n_neg_o ^ n_neg_i;
            end
        end
        n_out_item.value = w_neg ? (32'd0 - w_mag) : w_mag;
    end

    // Hold word state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIGN;
            r_neg_o     <= 1'b0;
            r_neg_i     <= 1'b0;
            r_radix     <= BASE_RESET;
            r_acc       <= 64'd0;
            r_failed    <= 1'b0;
            r_seen      <= 1'b0;
            r_code      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_head.last) begin
                r_phase     <= PH_SIGN;
                r_neg_o     <= 1'b0;
                r_neg_i     <= 1'b0;
                r_radix     <= BASE_RESET;
                r_acc       <= 64'd0;
                r_failed    <= 1'b0;
                r_seen      <= 1'b0;
                r_code      <= 8'd0;
                r_out_valid <= 1'b1;
                r_out_item  <= n_out_item;
            end else begin
                if (o_pop) begin
                    r_phase  <= n_phase;
                    r_neg_o  <= n_neg_o;
                    r_neg_i  <= n_neg_i;
                    r_radix  <= n_radix;
                    r_acc    <= n_acc;
                    r_failed <= n_failed;
                    r_seen   <= n_seen;
                    r_code   <= n_code;
                end
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.valid_res) |-> (r_out_item.value == 32'd0))
        else $error("invalid word with nonzero value");

    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SIGN) |-> (r_radix >= BASE_MIN && r_radix <= BASE_MAX))
        else $error("radix out of range inside a word");

endmodule

[hw/rtl/forth_number_literal_parser.sv]
// ============================================================================
// forth_number_literal_parser - ASCII radix number parser, top level
// Parses a word, one character per item, into a 32-bit cell.
// ============================================================================
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_stall      | i_in_item  (ch, last)
//  out     | output    | o_out_valid / i_out_stall    | o_out_item (valid_res, value)
//  cfg     | input     | i_cfg_valid / o_cfg_ready    | i_cfg_data (default_base)
//
//  One character per cycle is sustained unless a stalled result fills the
//  queue; the parse engine walks all grammar phases of a character and one
//  64x6 multiply-add combinationally. A word's result passes through the
//  queue and then the output register after its last character is accepted.
//  Reset is synchronous, active low; it sets the default base to ten and
//  empties the queue. The four-entry queue lets input accept while the
//  output is stalled; a stalled result only blocks the next last character.
//
module forth_number_literal_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fnlp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fnlp_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [5:0]          i_cfg_data
);
    import fnlp_pkg::*;

    logic [5:0] w_base;
    logic       w_full;
    logic       w_push;
    t_cls       w_push_item;
    logic       w_pop;
    logic       w_empty;
    t_cls       w_head;

    // Accept and classify characters
    fnlp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_base      (w_base),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_item (w_push_item)
    );

    // Buffer classified items
    fnlp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_empty     (w_empty),
        .o_head      (w_head)
    );

    // Parse and deliver results
    fnlp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base      (w_base),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
